// ===== hw/rtl/mrie_pkg.sv =====
`timescale 1ns / 1ps
package mrie_pkg;
    localparam int MemWords = 256;
    localparam int RegCount = 16;
    localparam int StackRegIndex = 15;
    localparam int MemAw = $clog2(MemWords);
    localparam int RegAw = $clog2(RegCount);
    localparam int QDepth = 2;

    typedef enum logic [4:0] {
        OP_COP = 5'd0, OP_COP_REG = 5'd1, OP_AFC = 5'd2, OP_AFC_REG = 5'd3,
        OP_AFC_REL_REG = 5'd4, OP_ADD = 5'd5, OP_MUL = 5'd6, OP_SOU = 5'd7,
        OP_SOU_REG_VAL = 5'd8, OP_DIV = 5'd9, OP_PRI = 5'd10, OP_INF = 5'd11,
        OP_SUP = 5'd12, OP_EQU = 5'd13, OP_LABEL = 5'd14, OP_JMP = 5'd15,
        OP_JMF = 5'd16, OP_PUSH_REG = 5'd17, OP_CALL = 5'd18, OP_STOP = 5'd19
    } t_op;

    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StUnknown = 2'd1;
    localparam logic [1:0] StDivZero = 2'd2;

    typedef struct packed {
        logic        known;
        t_op         op;
        logic [15:0] op_a;
        logic [31:0] op_b;
        logic [31:0] op_c;
        logic [15:0] instr_index;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_OUT
    } t_state;
endpackage

// ===== hw/rtl/mrie_front.sv =====
`timescale 1ns / 1ps
module mrie_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [4:0]           i_func,
    input  logic [15:0]          i_op_a,
    input  logic [31:0]          i_op_b,
    input  logic [31:0]          i_op_c,
    input  logic [15:0]          i_instr_index,
    output logic                 o_q_valid,
    input  logic                 i_q_ready,
    output mrie_pkg::t_item      o_q_item
);
    // small FIFO between decode and execute
    mrie_pkg::t_item r_q [mrie_pkg::QDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    mrie_pkg::t_item w_item;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != 2'(mrie_pkg::QDepth));
    assign w_push = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop = o_q_valid && i_q_ready;
    assign o_q_item = r_q[r_rp];

    always_comb begin
        w_item.known = (i_func <= 5'd19);
        w_item.op = mrie_pkg::t_op'(i_func);
        w_item.op_a = i_op_a;
        w_item.op_b = i_op_b;
        w_item.op_c = i_op_c;
        w_item.instr_index = i_instr_index;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'(mrie_pkg::QDepth) |-> !w_push) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(mrie_pkg::QDepth)) else $error("queue count");
    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && !w_push |=> r_cnt == $past(r_cnt) - 2'd1) else $error("pop count");
`endif
endmodule

// ===== hw/rtl/mrie_div.sv =====
`timescale 1ns / 1ps
module mrie_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    output logic        o_done,
    output logic [31:0] o_q
);
    logic [31:0] r_rem, r_quo, r_den;
    logic r_neg, r_busy;
    logic [5:0] r_cnt;
    logic [32:0] w_trial;
    logic [31:0] w_shr;

    assign w_shr = {r_rem[30:0], r_quo[31]};
    assign w_trial = {1'b0, w_shr} - {1'b0, r_den};
    assign o_done = r_busy && (r_cnt == 6'd32);
    assign o_q = r_neg ? (32'd0 - r_quo) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= 6'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= 6'd0;
            r_rem <= 32'd0;
            r_quo <= i_x[31] ? 32'd0 - i_x : i_x;
            r_den <= i_y[31] ? 32'd0 - i_y : i_y;
            r_neg <= i_x[31] ^ i_y[31];
        end else if (r_busy) begin
            if (r_cnt == 6'd32) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 6'd1;
                if (!w_trial[32]) begin
                    r_rem <= w_trial[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= w_shr;
                    r_quo <= {r_quo[30:0], 1'b0};
                end
            end
        end
    end
endmodule

// ===== hw/rtl/mrie_back.sv =====
`timescale 1ns / 1ps
module mrie_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_ready,
    input  mrie_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [1:0]      o_status,
    output logic            o_print_valid,
    output logic [31:0]     o_print_value,
    output logic            o_jump_taken,
    output logic [15:0]     o_jump_label,
    output logic            o_halted
);
    localparam int MemAw = mrie_pkg::MemAw;
    localparam int RegAw = mrie_pkg::RegAw;
    localparam logic [RegAw-1:0] SpIdx = RegAw'(mrie_pkg::StackRegIndex % mrie_pkg::RegCount);

    // Memory cleared by a sweep after reset.
    logic [31:0] r_mem [mrie_pkg::MemWords];
    logic [31:0] r_regs [mrie_pkg::RegCount];
    logic [MemAw:0] r_clr;
    logic w_clearing;

    mrie_pkg::t_state r_state, n_state;
    mrie_pkg::t_item  r_it;
    logic [31:0] r_x, r_rdata;
    logic [MemAw-1:0] w_raddr;

    logic        w_we;
    logic [MemAw-1:0] w_waddr;
    logic [31:0] w_wdata;
    logic        w_rwe;
    logic [RegAw-1:0] w_rwaddr;
    logic [31:0] w_rwdata;
    logic [31:0] r_prod;
    logic [1:0]  r_st;
    logic        r_pv, r_jt, r_halt;
    logic [31:0] r_pval;
    logic [15:0] r_jl;
    logic        w_div_start, w_div_done;
    logic [31:0] w_div_q;
    logic        w_take;

    assign w_clearing = !r_clr[MemAw];
    assign w_take = i_q_valid && o_q_ready;

    mrie_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_x(r_x), .i_y(r_rdata), .o_done(w_div_done), .o_q(w_div_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mrie_pkg::S_IDLE: if (w_take) n_state = mrie_pkg::S_RD1;
            mrie_pkg::S_RD1:  n_state = mrie_pkg::S_RD2;
            mrie_pkg::S_RD2:  n_state = mrie_pkg::S_EXEC;
            mrie_pkg::S_EXEC:
                n_state = (r_it.known && r_it.op == mrie_pkg::OP_DIV && r_rdata != 32'd0)
                          ? mrie_pkg::S_DIV : mrie_pkg::S_OUT;
            mrie_pkg::S_DIV:  if (w_div_done) n_state = mrie_pkg::S_OUT;
            mrie_pkg::S_OUT:  if (i_ready) n_state = mrie_pkg::S_IDLE;
            default:          n_state = mrie_pkg::S_IDLE;
        endcase
    end

    // outputs and read address
    always_comb begin
        o_q_ready = (r_state == mrie_pkg::S_IDLE) && !w_clearing;
        o_valid = (r_state == mrie_pkg::S_OUT);
        w_div_start = 1'b0;
        w_raddr = r_it.op_a[MemAw-1:0];
        if (r_state == mrie_pkg::S_IDLE) w_raddr = i_item.op_b[MemAw-1:0];
        if (r_state == mrie_pkg::S_RD1) w_raddr = r_it.op_c[MemAw-1:0];
        if (r_state == mrie_pkg::S_RD2) begin
            case (r_it.op)
                mrie_pkg::OP_PRI, mrie_pkg::OP_JMF: w_raddr = r_it.op_a[MemAw-1:0];
                default: w_raddr = r_it.op_c[MemAw-1:0];
            endcase
        end
        if (r_state == mrie_pkg::S_EXEC && r_it.known && r_it.op == mrie_pkg::OP_DIV
            && r_rdata != 32'd0) w_div_start = 1'b1;
    end

    // execute: compute writes for the clear sweep and in EXEC/DIV
    always_comb begin
        logic [31:0] ra, rb, sum;
        ra = r_regs[r_it.op_a[RegAw-1:0]];
        rb = r_regs[r_it.op_b[RegAw-1:0]];
        sum = ra + r_it.op_b;
        w_we = 1'b0;
        w_waddr = r_it.op_a[MemAw-1:0];
        w_wdata = 32'd0;
        w_rwe = 1'b0;
        w_rwaddr = r_it.op_a[RegAw-1:0];
        w_rwdata = 32'd0;
        if (w_clearing) begin
            w_we = 1'b1;
            w_waddr = r_clr[MemAw-1:0];
        end else if (r_state == mrie_pkg::S_DIV) begin
            w_we = w_div_done;
            w_wdata = w_div_q;
        end else if (r_state == mrie_pkg::S_EXEC && r_it.known) begin
            case (r_it.op)
                mrie_pkg::OP_COP: begin w_we = 1'b1; w_wdata = r_x; end
                mrie_pkg::OP_COP_REG: begin w_rwe = 1'b1; w_rwdata = rb; end
                mrie_pkg::OP_AFC: begin w_we = 1'b1; w_wdata = r_it.op_b; end
                mrie_pkg::OP_AFC_REG: begin w_rwe = 1'b1; w_rwdata = r_it.op_b; end
                mrie_pkg::OP_AFC_REL_REG: begin
                    w_we = 1'b1; w_waddr = sum[MemAw-1:0]; w_wdata = r_it.op_c;
                end
                mrie_pkg::OP_ADD: begin w_we = 1'b1; w_wdata = r_x + r_rdata; end
                mrie_pkg::OP_MUL: begin w_we = 1'b1; w_wdata = r_prod; end
                mrie_pkg::OP_SOU: begin w_we = 1'b1; w_wdata = r_x - r_rdata; end
                mrie_pkg::OP_SOU_REG_VAL: begin
                    w_rwe = 1'b1; w_rwdata = rb - r_it.op_c;
                end
                mrie_pkg::OP_DIV: w_we = (r_rdata == 32'd0);
                mrie_pkg::OP_INF: begin
                    w_we = 1'b1; w_wdata = {31'd0, $signed(r_x) < $signed(r_rdata)};
                end
                mrie_pkg::OP_SUP: begin
                    w_we = 1'b1; w_wdata = {31'd0, $signed(r_rdata) < $signed(r_x)};
                end
                mrie_pkg::OP_EQU: begin w_we = 1'b1; w_wdata = {31'd0, r_x == r_rdata}; end
                mrie_pkg::OP_PUSH_REG, mrie_pkg::OP_CALL: begin
                    w_we = 1'b1;
                    w_waddr = r_regs[SpIdx][MemAw-1:0];
                    w_wdata = (r_it.op == mrie_pkg::OP_CALL)
                              ? {16'd0, r_it.instr_index} + 32'd1 : ra;
                    w_rwe = 1'b1; w_rwaddr = SpIdx; w_rwdata = r_regs[SpIdx] - 32'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_raddr];
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (w_take) r_it <= i_item;
        if (r_state == mrie_pkg::S_RD1) r_x <= r_rdata;
        r_prod <= r_x * r_rdata;
        // in EXEC the read data holds mem[op_a] for print and conditional jump
        if (r_state == mrie_pkg::S_EXEC) begin
            r_st <= !r_it.known ? mrie_pkg::StUnknown
                  : (r_it.op == mrie_pkg::OP_DIV && r_rdata == 32'd0) ? mrie_pkg::StDivZero
                  : mrie_pkg::StOk;
            r_pv <= r_it.known && r_it.op == mrie_pkg::OP_PRI;
            r_pval <= (r_it.known && r_it.op == mrie_pkg::OP_PRI) ? r_rdata : 32'd0;
            r_halt <= r_it.known && r_it.op == mrie_pkg::OP_STOP;
            r_jt <= r_it.known && (r_it.op == mrie_pkg::OP_JMP || r_it.op == mrie_pkg::OP_CALL
                    || (r_it.op == mrie_pkg::OP_JMF && r_rdata == 32'd0));
            r_jl <= !r_it.known ? 16'd0
                  : (r_it.op == mrie_pkg::OP_JMP || r_it.op == mrie_pkg::OP_CALL) ? r_it.op_a
                  : (r_it.op == mrie_pkg::OP_JMF && r_rdata == 32'd0) ? r_it.op_b[15:0]
                  : 16'd0;
        end
        if (!i_rst_n) begin
            r_state <= mrie_pkg::S_IDLE;
            r_clr <= '0;
            for (int k = 0; k < mrie_pkg::RegCount; k++) r_regs[k] <= 32'd0;
        end else begin
            r_state <= n_state;
            if (w_clearing) r_clr <= r_clr + 1'b1;
            if (w_rwe) r_regs[w_rwaddr] <= w_rwdata;
        end
    end

    assign o_status = r_st;
    assign o_print_valid = r_pv;
    assign o_print_value = r_pval;
    assign o_jump_taken = r_jt;
    assign o_jump_label = r_jl;
    assign o_halted = r_halt;

`ifndef SYNTHESIS
    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !w_take) else $error("item taken during clear");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)) else $error("result dropped");
    a_div_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mrie_pkg::S_DIV |-> r_it.op == mrie_pkg::OP_DIV) else $error("div state");
`endif
endmodule

// ===== hw/rtl/memory_register_instruction_executor_top.sv =====
`timescale 1ns / 1ps
// Executes one instruction per transaction against a 256-word data memory and a
// 16-entry register file. After reset the memory is cleared by a sweep during
// which the back takes no instruction from the queue. Each instruction passes
// through three reads on the single memory read port (IDLE, RD1, RD2), then an
// execute state and an output state; divide adds a pass through the bit-serial
// divider. A two-entry queue decouples the accepting front from the executing
// back. Jumps report a label id only.
module memory_register_instruction_executor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_func,
    input  logic [15:0] i_op_a,
    input  logic [31:0] i_op_b,
    input  logic [31:0] i_op_c,
    input  logic [15:0] i_instr_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_print_valid,
    output logic [31:0] o_print_value,
    output logic        o_jump_taken,
    output logic [15:0] o_jump_label,
    output logic        o_halted
);
    logic w_qv, w_qr;
    mrie_pkg::t_item w_item;

    // front: accept and classify
    mrie_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_func(i_func), .i_op_a(i_op_a), .i_op_b(i_op_b), .i_op_c(i_op_c),
        .i_instr_index(i_instr_index), .o_q_valid(w_qv), .i_q_ready(w_qr),
        .o_q_item(w_item)
    );

    // back: execute against memory and registers
    mrie_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_qv), .o_q_ready(w_qr),
        .i_item(w_item), .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
        .o_print_valid(o_print_valid), .o_print_value(o_print_value),
        .o_jump_taken(o_jump_taken), .o_jump_label(o_jump_label), .o_halted(o_halted)
    );
endmodule

// ===== test/memory_register_instruction_executor_top_test.sv =====
`timescale 1ns / 1ps
module memory_register_instruction_executor_top_test;

    localparam int MemLen = 256;
    localparam int RegLen = 16;
    localparam int SpIndex = 15 % 16;
    localparam int NumRandom = 1100;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [4:0]  i_func;
    logic [15:0] i_op_a;
    logic [31:0] i_op_b;
    logic [31:0] i_op_c;
    logic [15:0] i_instr_index;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic        o_print_valid;
    logic [31:0] o_print_value;
    logic        o_jump_taken;
    logic [15:0] o_jump_label;
    logic        o_halted;

    memory_register_instruction_executor_top uut (.*);

    typedef struct {
        logic [1:0]  status;
        logic        print_valid;
        logic [31:0] print_value;
        logic        jump_taken;
        logic [15:0] jump_label;
        logic        halted;
    } t_outcome;

    // Shadow copy of the executor state.
    logic [31:0] shadow_mem [MemLen];
    logic [31:0] shadow_reg [RegLen];
    t_outcome    pending_outcomes [$];
    int          error_count;
    int          long_stall;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous fixed limit: sweep, ~1200 items with divides and long stalls.
    initial begin
        #20ms;
        $display("memory_register_instruction_executor_top verification failed");
        $finish;
    end

    function automatic logic [7:0] mem_addr(input logic [31:0] v);
        return v[7:0];
    endfunction

    function automatic logic [3:0] reg_addr(input logic [31:0] v);
        return v[3:0];
    endfunction

    function automatic logic [31:0] signed_quotient(input logic [31:0] x,
                                                    input logic [31:0] y);
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] q;
        mx = x[31] ? -x : x;
        my = y[31] ? -y : y;
        q = mx / my;
        return (x[31] != y[31]) ? -q : q;
    endfunction

    function automatic void push_stack(input logic [31:0] v);
        shadow_mem[mem_addr(shadow_reg[SpIndex])] = v;
        shadow_reg[SpIndex] = shadow_reg[SpIndex] - 32'd1;
    endfunction

    // Execute one instruction on the shadow state and return its outcome.
    function automatic t_outcome execute_instruction(input logic [4:0] func,
            input logic [15:0] a, input logic [31:0] b, input logic [31:0] c,
            input logic [15:0] idx);
        t_outcome    r;
        logic [7:0]  ma;
        logic [31:0] vb;
        logic [31:0] vc;
        r = '{default: '0};
        ma = mem_addr({16'd0, a});
        vb = shadow_mem[mem_addr(b)];
        vc = shadow_mem[mem_addr(c)];
        case (func)
            mrie_pkg::OP_COP: shadow_mem[ma] = vb;
            mrie_pkg::OP_COP_REG:
                shadow_reg[reg_addr({16'd0, a})] = shadow_reg[reg_addr(b)];
            mrie_pkg::OP_AFC: shadow_mem[ma] = b;
            mrie_pkg::OP_AFC_REG: shadow_reg[reg_addr({16'd0, a})] = b;
            mrie_pkg::OP_AFC_REL_REG:
                shadow_mem[mem_addr(shadow_reg[reg_addr({16'd0, a})] + b)] = c;
            mrie_pkg::OP_ADD: shadow_mem[ma] = vb + vc;
            mrie_pkg::OP_MUL: shadow_mem[ma] = vb * vc;
            mrie_pkg::OP_SOU: shadow_mem[ma] = vb - vc;
            mrie_pkg::OP_SOU_REG_VAL:
                shadow_reg[reg_addr({16'd0, a})] = shadow_reg[reg_addr(b)] - c;
            mrie_pkg::OP_DIV: begin
                if (vc == 32'd0) begin
                    shadow_mem[ma] = 32'd0;
                    r.status = mrie_pkg::StDivZero;
                end else begin
                    shadow_mem[ma] = signed_quotient(vb, vc);
                end
            end
            mrie_pkg::OP_PRI: begin
                r.print_valid = 1'b1;
                r.print_value = shadow_mem[ma];
            end
            mrie_pkg::OP_INF: shadow_mem[ma] = {31'd0, $signed(vb) < $signed(vc)};
            mrie_pkg::OP_SUP: shadow_mem[ma] = {31'd0, $signed(vc) < $signed(vb)};
            mrie_pkg::OP_EQU: shadow_mem[ma] = {31'd0, vb == vc};
            mrie_pkg::OP_LABEL: ;
            mrie_pkg::OP_JMP: begin
                r.jump_taken = 1'b1;
                r.jump_label = a;
            end
            mrie_pkg::OP_JMF: begin
                if (shadow_mem[ma] == 32'd0) begin
                    r.jump_taken = 1'b1;
                    r.jump_label = b[15:0];
                end
            end
            mrie_pkg::OP_PUSH_REG: push_stack(shadow_reg[reg_addr({16'd0, a})]);
            mrie_pkg::OP_CALL: begin
                push_stack({16'd0, idx} + 32'd1);
                r.jump_taken = 1'b1;
                r.jump_label = a;
            end
            mrie_pkg::OP_STOP: r.halted = 1'b1;
            default: r.status = mrie_pkg::StUnknown;
        endcase
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int random_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Send one transaction and record its expected outcome at acceptance.
    // Valid stays high into a back-to-back item; drop it only for a gap.
    task automatic send_instruction(input logic [4:0] func, input logic [15:0] a,
            input logic [31:0] b, input logic [31:0] c, input logic [15:0] idx);
        int gap;
        gap = random_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= func;
        i_op_a <= a;
        i_op_b <= b;
        i_op_c <= c;
        i_instr_index <= idx;
        do @(posedge i_clk); while (!o_ready);
        pending_outcomes.push_back(execute_instruction(func, a, b, c, idx));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random backpressure, compare each transaction field by field.
    initial begin
        t_outcome want;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: unexpected result transaction", $time);
                    error_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status exp %0d got %0d", $time, want.status, o_status);
                        error_count++;
                    end
                    if (o_print_valid !== want.print_valid) begin
                        $display("%0t: print_valid exp %0d got %0d", $time,
                                 want.print_valid, o_print_valid);
                        error_count++;
                    end
                    if (o_print_value !== want.print_value) begin
                        $display("%0t: print_value exp %h got %h", $time,
                                 want.print_value, o_print_value);
                        error_count++;
                    end
                    if (o_jump_taken !== want.jump_taken) begin
                        $display("%0t: jump_taken exp %0d got %0d", $time,
                                 want.jump_taken, o_jump_taken);
                        error_count++;
                    end
                    if (o_jump_label !== want.jump_label) begin
                        $display("%0t: jump_label exp %h got %h", $time,
                                 want.jump_label, o_jump_label);
                        error_count++;
                    end
                    if (o_halted !== want.halted) begin
                        $display("%0t: halted exp %0d got %0d", $time, want.halted, o_halted);
                        error_count++;
                    end
                end
            end
            // Hold ready low for a random stretch, or else set it high at random, 70 percent of the time.
            if (long_stall > 0) begin
                long_stall--;
                i_ready <= 1'b0;
            end else if ($urandom_range(99) < 4) begin
                long_stall = $urandom_range(30, 8);
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) < 70);
            end
        end
    end

    // Small addresses so that reads hit written words; wrap aliases now and then.
    function automatic logic [31:0] pick_addr();
        logic [31:0] v;
        v = $urandom_range(15);
        if ($urandom_range(9) == 0) v = v + (32'($urandom) << 8);
        return v;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return $urandom_range(8);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed_corners();
        // Extremes of the memory fields, signed divide edge cases.
        send_instruction(mrie_pkg::OP_AFC, 16'd1, 32'h8000_0000, 32'd0, 16'd0);
        send_instruction(mrie_pkg::OP_AFC, 16'd2, 32'hFFFF_FFFF, 32'd0, 16'd1);
        send_instruction(mrie_pkg::OP_DIV, 16'd3, 32'd1, 32'd2, 16'd2);    // overflow wraps
        send_instruction(mrie_pkg::OP_DIV, 16'd4, 32'd1, 32'd9, 16'd3);    // divide by zero
        send_instruction(mrie_pkg::OP_AFC, 16'd5, 32'hFFFF_FFF9, 32'd0, 16'd4);
        send_instruction(mrie_pkg::OP_AFC, 16'd6, 32'd2, 32'd0, 16'd5);
        send_instruction(mrie_pkg::OP_DIV, 16'd7, 32'd5, 32'd6, 16'd6);    // truncate toward zero
        send_instruction(mrie_pkg::OP_ADD, 16'hFFFF, 32'd1, 32'hFFFF_FF02, 16'd7); // address wrap
        send_instruction(mrie_pkg::OP_MUL, 16'd8, 32'd1, 32'd2, 16'd8);
        send_instruction(mrie_pkg::OP_SOU, 16'd9, 32'd5, 32'd1, 16'd9);
        send_instruction(mrie_pkg::OP_INF, 16'd10, 32'd1, 32'd2, 16'd10);
        send_instruction(mrie_pkg::OP_SUP, 16'd11, 32'd1, 32'd2, 16'd11);
        send_instruction(mrie_pkg::OP_EQU, 16'd12, 32'd2, 32'd2, 16'd12);
        send_instruction(mrie_pkg::OP_PRI, 16'd7, 32'd0, 32'd0, 16'd13);
        send_instruction(mrie_pkg::OP_COP, 16'd13, 32'd1, 32'd0, 16'd14);
        send_instruction(mrie_pkg::OP_AFC_REG, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 16'd15); // reg wrap
        send_instruction(mrie_pkg::OP_COP_REG, 16'd0, 32'd15, 32'd0, 16'd16);
        send_instruction(mrie_pkg::OP_SOU_REG_VAL, 16'd1, 32'd0, 32'h8000_0000, 16'd17);
        send_instruction(mrie_pkg::OP_AFC_REL_REG, 16'd0, 32'd3, 32'h1234_5678, 16'd18);
        send_instruction(mrie_pkg::OP_PUSH_REG, 16'd1, 32'd0, 32'd0, 16'd19);
        send_instruction(mrie_pkg::OP_AFC_REG, 16'd15, 32'd0, 32'd0, 16'd20);
        send_instruction(mrie_pkg::OP_CALL, 16'hFFFF, 32'd0, 32'd0, 16'hFFFF); // stack wraps below 0
        send_instruction(mrie_pkg::OP_JMF, 16'd200, 32'hABCD_1234, 32'd0, 16'd22);
        send_instruction(mrie_pkg::OP_JMP, 16'hA5A5, 32'd0, 32'd0, 16'd23);
        send_instruction(mrie_pkg::OP_LABEL, 16'd3, 32'd0, 32'd0, 16'd24);
        send_instruction(mrie_pkg::OP_STOP, 16'd0, 32'd0, 32'd0, 16'd25);
        send_instruction(5'd31, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_instruction(5'd20, 16'd0, 32'd0, 32'd0, 16'd0);
    endtask

    task automatic test_random_program();
        int n;
        logic [4:0] func;
        for (n = 0; n < NumRandom; n++) begin
            // Mostly valid opcodes, a few unknown ones.
            func = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 20))
                                             : 5'($urandom_range(19));
            if (n % 8 == 0) func = mrie_pkg::OP_AFC;   // keep memory seeded with values
            case ($urandom_range(3))
                0: send_instruction(func, 16'($urandom), $urandom, $urandom, 16'($urandom));
                default: send_instruction(func, 16'(pick_addr()), (func == mrie_pkg::OP_AFC ||
                        func == mrie_pkg::OP_AFC_REG) ? pick_value() : pick_addr(),
                        pick_value() & ((func == mrie_pkg::OP_AFC_REL_REG ||
                        func == mrie_pkg::OP_SOU_REG_VAL) ? 32'hFFFF_FFFF : 32'h0000_000F),
                        16'($urandom));
            endcase
            if (n == NumRandom / 2) wait_drained();  // let every result come home
        end
    endtask

    initial begin
        int k;
        error_count = 0;
        long_stall = 0;
        for (k = 0; k < MemLen; k++) shadow_mem[k] = '0;
        for (k = 0; k < RegLen; k++) shadow_reg[k] = '0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_func <= '0;
        i_op_a <= '0;
        i_op_b <= '0;
        i_op_c <= '0;
        i_instr_index <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_corners();
        test_random_program();
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("memory_register_instruction_executor_top verification clean");
        end else begin
            $display("memory_register_instruction_executor_top verification failed");
        end
        $finish;
    end
endmodule
